### hw/rtl/dlse_pkg.sv
// Package with shared types and constants of the dense layer training engine.
`timescale 1ns / 1ps
package dlse_pkg;
   localparam logic [2:0] OP_LOAD_W = 3'd0;
   localparam logic [2:0] OP_LOAD_B = 3'd1;
   localparam logic [2:0] OP_FWD    = 3'd2;
   localparam logic [2:0] OP_GRAD   = 3'd3;
   localparam logic [2:0] OP_READ_W = 3'd4;
   localparam logic [2:0] OP_READ_B = 3'd5;

   localparam logic [1:0] KIND_FWD   = 2'd0;
   localparam logic [1:0] KIND_IGRAD = 2'd1;
   localparam logic [1:0] KIND_WREAD = 2'd2;
   localparam logic [1:0] KIND_BREAD = 2'd3;

   localparam logic signed [39:0] ACC40_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [39:0] ACC40_MIN = 40'sh80_0000_0000;
   localparam logic signed [23:0] ACC24_MAX = 24'sh7F_FFFF;
   localparam logic signed [23:0] ACC24_MIN = 24'sh80_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_RD, ST_FWD_AC, ST_FWD_OUT,
      ST_GRD_RD, ST_GRD_AC, ST_GRD_OUT,
      ST_UPD_RD, ST_UPD_MUL, ST_UPD_WR,
      ST_BUPD_RD, ST_BUPD_WR,
      ST_READ,
      ST_CLEAR
   } state_type;

   // Saturating add of a 40-bit accumulator and a 40-bit signed term.
   function automatic logic signed [39:0] sat_add40(logic signed [39:0] a,
                                                    logic signed [39:0] b);
      logic signed [40:0] s;
      s = {a[39], a} + {b[39], b};
      if (s > 41'(ACC40_MAX)) return ACC40_MAX;
      if (s < 41'(ACC40_MIN)) return ACC40_MIN;
      return s[39:0];
   endfunction

   // Round half up a Q.24 value to Q4.12 with saturation; bit 16 is the flag.
   function automatic logic [16:0] round_q12(logic signed [40:0] acc);
      logic signed [41:0] r;
      r = ($signed({acc[40], acc}) + 42'sd2048) >>> 12;
      if (r > 42'sd32767) return {1'b1, 16'h7FFF};
      if (r < -42'sd32768) return {1'b1, 16'h8000};
      return {1'b0, r[15:0]};
   endfunction

   function automatic logic signed [15:0] sat16(logic signed [40:0] v);
      if (v > 41'sd32767) return 16'sh7FFF;
      if (v < -41'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction
endpackage

### hw/rtl/dense_layer_sgd_engine.sv
// Top level of the dense layer training engine: sequencer, memories and datapath.
`timescale 1ns / 1ps
// A load is accepted while idle; a read, a forward element and a gradient element keep busy
// high until done, so a new request waits. A forward element on the last feature also sends
// OUT_SIZE results, a gradient element on the last column IN_SIZE results, and end of batch
// there adds a weight and bias update pass. The receiver cannot stall. Reset is synchronous and
// active high; after it, busy stays high during a pass that clears the gradient memories.
module dense_layer_sgd_engine
   import dlse_pkg::*;
#(
   parameter int IN_SIZE   = 64,
   parameter int OUT_SIZE  = 16,
   parameter int MAX_BATCH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic [5:0]         req_in_index,
   input  logic [5:0]         req_out_index,
   input  logic [5:0]         req_sample,
   input  logic signed [15:0] req_value,
   input  logic               req_end_of_batch,
   input  logic               csr_write,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_kind,
   output logic [5:0]         rsp_index,
   output logic signed [15:0] rsp_result_value,
   output logic               rsp_last,
   output logic               rsp_saturated
);
   localparam int NW = IN_SIZE * OUT_SIZE;
   localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
   localparam int IW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
   localparam int OW = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
   localparam int SAW = (MAX_BATCH * IN_SIZE > 1) ? $clog2(MAX_BATCH * IN_SIZE) : 1;

   // Memories. The gradient memories are zeroed by the clearing pass after reset.
   logic signed [15:0] wmem [NW];
   logic signed [39:0] gmem [NW];
   logic signed [15:0] xmem [MAX_BATCH * IN_SIZE];
   logic signed [39:0] iacc_mem [IN_SIZE];
   logic signed [15:0] bias_ff [OUT_SIZE];
   logic signed [39:0] oacc_ff [OUT_SIZE];
   logic signed [23:0] bacc_ff [OUT_SIZE];

   state_type state_ff, state_in;
   logic [15:0] lr_ff;
   logic [2:0] op_ff;
   logic [IW-1:0] i_ff;
   logic [OW-1:0] j_ff;
   logic [5:0] j6_ff;
   logic [SAW-1:0] sbase_ff;
   logic signed [15:0] v_ff;
   logic eob_ff, okr_ff;
   logic [WAW:0] cnt_ff, cnt_in;
   logic signed [15:0] wrd_ff, xrd_ff;
   logic signed [39:0] grd_ff, iacc_rd_ff;
   logic signed [55:0] prod_ff;
   logic signed [23:0] bdel_ff;

   logic [WAW-1:0] waddr, ga, waddr_q;
   logic [IW-1:0] ck_i;
   logic [OW-1:0] ck_j;
   logic acc_go;
   logic iacc_we;
   logic [IW-1:0] iacc_wa, iacc_ra;
   logic signed [39:0] iacc_wd;
   logic signed [24:0] bsum;

   assign busy = (state_ff != ST_IDLE);
   assign acc_go = start && !busy;

   // The count runs rows for gradient work and columns for forward work.
   assign ck_i = cnt_ff[IW-1:0];
   assign ck_j = cnt_ff[OW-1:0];
   assign ga   = cnt_ff[WAW-1:0];

   always_comb begin
      waddr = '0;
      case (state_ff)
         ST_FWD_RD: waddr = WAW'(i_ff * OUT_SIZE + ck_j);
         ST_GRD_RD: waddr = WAW'(ck_i * OUT_SIZE + j_ff);
         default:   waddr = ga;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (acc_go) begin
               case (req_opcode)
                  OP_FWD:
                     if (32'(req_in_index) < IN_SIZE && 32'(req_sample) < MAX_BATCH)
                        state_in = ST_FWD_RD;
                  OP_GRAD:
                     if (32'(req_out_index) < OUT_SIZE && 32'(req_sample) < MAX_BATCH)
                        state_in = ST_GRD_RD;
                  OP_READ_W, OP_READ_B: state_in = ST_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (32'(cnt_ff) == NW - 1) begin
               cnt_in = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FWD_RD: state_in = ST_FWD_AC;
         ST_FWD_AC: begin
            if (32'(cnt_ff) == OUT_SIZE - 1) begin
               cnt_in = '0;
               state_in = (32'(i_ff) == IN_SIZE - 1) ? ST_FWD_OUT : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_FWD_RD;
            end
         end
         ST_FWD_OUT: begin
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == OUT_SIZE - 1) state_in = ST_IDLE;
         end
         ST_GRD_RD: state_in = ST_GRD_AC;
         ST_GRD_AC: begin
            if (32'(cnt_ff) == IN_SIZE - 1) begin
               cnt_in = '0;
               state_in = (32'(j_ff) == OUT_SIZE - 1) ? ST_GRD_OUT : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_GRD_RD;
            end
         end
         ST_GRD_OUT: begin
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == IN_SIZE - 1) begin
               cnt_in = '0;
               state_in = eob_ff ? ST_UPD_RD : ST_IDLE;
            end
         end
         ST_UPD_RD:  state_in = ST_UPD_MUL;
         ST_UPD_MUL: state_in = ST_UPD_WR;
         ST_UPD_WR: begin
            if (32'(cnt_ff) == NW - 1) begin
               cnt_in = '0;
               state_in = ST_BUPD_RD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_UPD_RD;
            end
         end
         ST_BUPD_RD: state_in = ST_BUPD_WR;
         ST_BUPD_WR: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = ST_BUPD_RD;
            if (32'(cnt_ff) == OUT_SIZE - 1) state_in = ST_IDLE;
         end
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         lr_ff <= 16'd655;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (csr_write) lr_ff <= csr_wdata;
      end
   end

   // Bias gradient sum with one guard bit for saturation.
   assign bsum = 25'(bacc_ff[j_ff]) + 25'(v_ff);

   // Accumulators with reset value zero are small register arrays.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < OUT_SIZE; k++) begin
            oacc_ff[k] <= '0;
            bacc_ff[k] <= '0;
         end
      end else begin
         case (state_ff)
            ST_FWD_AC:
               oacc_ff[ck_j] <= sat_add40(oacc_ff[ck_j], 40'(v_ff * wrd_ff));
            ST_FWD_OUT: oacc_ff[ck_j] <= '0;
            ST_GRD_AC: begin
               if (cnt_ff == '0) begin
                  if (bsum > 25'(ACC24_MAX))
                     bacc_ff[j_ff] <= ACC24_MAX;
                  else if (bsum < 25'(ACC24_MIN))
                     bacc_ff[j_ff] <= ACC24_MIN;
                  else
                     bacc_ff[j_ff] <= bsum[23:0];
               end
            end
            ST_BUPD_WR: bacc_ff[ck_j] <= '0;
            default: ;
         endcase
      end
   end

   // Input gradient memory. It is read at the next count so that the data is ready in
   // the cycle that uses it; a write to the same entry at that edge is forwarded.
   always_comb begin
      iacc_we = 1'b0;
      iacc_wa = ck_i;
      iacc_wd = '0;
      iacc_ra = cnt_in[IW-1:0];
      case (state_ff)
         ST_CLEAR:   iacc_we = (32'(cnt_ff) < IN_SIZE);
         ST_GRD_AC: begin
            iacc_we = 1'b1;
            iacc_wd = sat_add40(iacc_rd_ff, 40'(v_ff * wrd_ff));
         end
         ST_GRD_OUT: iacc_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (iacc_we) iacc_mem[iacc_wa] <= iacc_wd;
      iacc_rd_ff <= (iacc_we && iacc_wa == iacc_ra) ? iacc_wd : iacc_mem[iacc_ra];
   end

   // Captured request fields.
   always_ff @(posedge clock) begin
      if (acc_go) begin
         op_ff <= req_opcode;
         i_ff <= req_in_index[IW-1:0];
         j_ff <= req_out_index[OW-1:0];
         j6_ff <= req_out_index;
         sbase_ff <= SAW'(req_sample * IN_SIZE);
         v_ff <= req_value;
         eob_ff <= req_end_of_batch;
         okr_ff <= (32'(req_out_index) < OUT_SIZE) &&
                   (req_opcode == OP_READ_B || 32'(req_in_index) < IN_SIZE);
      end
   end

   // Weight memory port, loads, and the sweep write-back.
   always_ff @(posedge clock) begin
      if (acc_go && req_opcode == OP_LOAD_W &&
          32'(req_in_index) < IN_SIZE && 32'(req_out_index) < OUT_SIZE)
         wmem[WAW'(req_in_index * OUT_SIZE + req_out_index)] <= req_value;
      else if (acc_go && req_opcode == OP_READ_W)
         wrd_ff <= wmem[WAW'(req_in_index * OUT_SIZE + req_out_index)];
      else if (state_ff == ST_UPD_WR)
         wmem[ga] <= sat16(41'(wrd_ff) - 41'((prod_ff + 56'sd134217728) >>> 28));
      else
         wrd_ff <= wmem[waddr];
   end

   always_ff @(posedge clock) begin
      if (acc_go && req_opcode == OP_LOAD_B && 32'(req_out_index) < OUT_SIZE)
         bias_ff[req_out_index[OW-1:0]] <= req_value;
      else if (state_ff == ST_BUPD_WR)
         bias_ff[ck_j] <= sat16(41'(bias_ff[ck_j]) - 41'(bdel_ff));
   end

   // Saved input memory: written by forward elements, read during gradient sweeps.
   always_ff @(posedge clock) begin
      if (acc_go && req_opcode == OP_FWD &&
          32'(req_in_index) < IN_SIZE && 32'(req_sample) < MAX_BATCH)
         xmem[SAW'(req_sample * IN_SIZE + req_in_index)] <= req_value;
      xrd_ff <= xmem[SAW'(sbase_ff + ck_i)];
   end

   // Weight gradient memory: registered read, written in the accumulate state, zeroed by update and clearing.
   always_ff @(posedge clock) begin
      if (state_ff == ST_GRD_AC)
         gmem[waddr_q] <= sat_add40(grd_ff, 40'(xrd_ff * v_ff));
      else if (state_ff == ST_UPD_WR || state_ff == ST_CLEAR)
         gmem[ga] <= '0;
      grd_ff <= gmem[waddr];
   end

   always_ff @(posedge clock) waddr_q <= waddr;

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD_MUL)
         prod_ff <= 56'(grd_ff) * $signed({1'b0, lr_ff});
      if (state_ff == ST_BUPD_RD)
         bdel_ff <= 24'((40'(bacc_ff[ck_j]) * $signed({1'b0, lr_ff}) + 40'sd32768)
                        >>> 16);
   end

   // Result port.
   logic [16:0] rnd;
   always_comb begin
      rnd = '0;
      rsp_strobe = 1'b0;
      rsp_kind = KIND_FWD;
      rsp_index = '0;
      rsp_last = 1'b0;
      case (state_ff)
         ST_FWD_OUT: begin
            rnd = round_q12({oacc_ff[ck_j][39], oacc_ff[ck_j]} +
                            41'(bias_ff[ck_j] * 32'sd4096));
            rsp_strobe = 1'b1;
            rsp_index = 6'(ck_j);
            rsp_last = (32'(cnt_ff) == OUT_SIZE - 1);
         end
         ST_GRD_OUT: begin
            rnd = round_q12({iacc_rd_ff[39], iacc_rd_ff});
            rsp_strobe = 1'b1;
            rsp_kind = KIND_IGRAD;
            rsp_index = 6'(ck_i);
            rsp_last = (32'(cnt_ff) == IN_SIZE - 1);
         end
         ST_READ: begin
            rsp_strobe = 1'b1;
            rsp_index = j6_ff;
            rsp_last = 1'b1;
            if (op_ff == OP_READ_W) begin
               rsp_kind = KIND_WREAD;
               rnd = {1'b0, okr_ff ? wrd_ff : 16'sd0};
            end else begin
               rsp_kind = KIND_BREAD;
               rnd = {1'b0, okr_ff ? bias_ff[j_ff] : 16'sd0};
            end
         end
         default: ;
      endcase
      rsp_result_value = rnd[15:0];
      rsp_saturated = rnd[16];
   end
endmodule
